/* rtl/ped_pkg.sv */
// Shared types and constants for the pairwise Euclidean distance block.
// No dependencies; used by the top level and by the port checker.
package ped_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned MAG_W   = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * MAG_W;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned SUM_W   = 2 * DIST_W;
  localparam int unsigned REM_W   = DIST_W + 3;
  localparam int unsigned STEP_W  = $clog2(DIST_W + 1);
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned NPTS_W  = 4;
  localparam int unsigned NDIMS_W = 3;

  localparam logic [NPTS_W-1:0]  NPTS_RESET  = 4'd8;
  localparam logic [NDIMS_W-1:0] NDIMS_RESET = 3'd4;

  // register indexes on the configuration port
  localparam logic CFG_POINTS = 1'b0;
  localparam logic CFG_DIMS   = 1'b1;

  // input item kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [2:0]  point_index;
    logic [1:0]  dim_index;
    logic signed [15:0] coord_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  row_point;
    logic [2:0]  col_point;
    logic [17:0] distance;
    logic        last;
  } out_item_t;

endpackage

/* rtl/ped_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; holds the coordinate store of the distance block.
module ped_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/pairwise_euclidean_distance.sv */
// Pairwise Euclidean distance over a small coordinate store. A write item
// (kind 0) stores one signed Q8.8 coordinate; writes to a point or
// dimension beyond the store are dropped. A compute item (kind 1) emits
// one result per pair, outer point j ascending, inner point i > j ascending,
// with last set on the final pair; fewer than two points gives no results.
// Each distance is floor(sqrt(sum of squared differences)) in unsigned Q.8.
// For each pair, each dimension in use reads two coordinates from the
// single-port store and passes the shared subtract, multiply and accumulate
// path, then an 18-step bit-serial square root runs and the result waits
// out any output stall. The input is stalled for the whole run. The
// coordinate store is not cleared by reset; read only written entries.
module pairwise_euclidean_distance #(
  parameter int unsigned MAX_POINTS = 8,
  parameter int unsigned MAX_DIMS   = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [ped_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ped_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ped_pkg::out_item_t          out_data_o
);

  localparam int unsigned PtW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DimW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DcntW = $clog2(MAX_DIMS + 1);
  localparam int unsigned Depth = MAX_POINTS * (2 ** DimW);
  localparam int unsigned AddrW = PtW + DimW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDA  = 8'b0000_0010,
    S_RDB  = 8'b0000_0100,
    S_DIFF = 8'b0000_1000,
    S_SQR  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_ROOT = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [ped_pkg::NPTS_W-1:0]  npts_q;
  logic [ped_pkg::NDIMS_W-1:0] ndims_q;
  logic [PtW-1:0]              i_q, i_d, j_q, j_d;
  logic [DcntW-1:0]            s_q, s_d;
  logic [ped_pkg::STEP_W-1:0]  step_q, step_d;

  logic [ped_pkg::COORD_W-1:0] a_q, a_d;
  logic [ped_pkg::MAG_W-1:0]   mag_q, mag_d;
  logic [ped_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic [ped_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [ped_pkg::SUM_W-1:0]   rad_q, rad_d;
  logic [ped_pkg::REM_W-1:0]   rem_q, rem_d;
  logic [ped_pkg::DIST_W-1:0]  root_q, root_d;
  ped_pkg::out_item_t          out_q, out_d;

  logic [3:0]                  n_eff, p_eff;
  logic                        ram_we;
  logic [AddrW-1:0]            ram_addr;
  logic [ped_pkg::COORD_W-1:0] ram_wdata, ram_rdata;

  logic [31:0]                 wr_pt, wr_dm, i_wide, j_wide, n_wide, p_wide;
  logic signed [ped_pkg::MAG_W-1:0] diff;
  logic [ped_pkg::SUM_W-1:0]   sum_nx;
  logic [ped_pkg::REM_W-1:0]   rem_sh, trial;
  logic                        root_bit;
  logic [ped_pkg::DIST_W-1:0]  root_nx;
  logic                        pair_go, root_go;
  logic [ped_pkg::SUM_W-1:0]   root_rad;

  // clamp the configured counts to the store size
  always_comb begin
    if (32'(npts_q) > MAX_POINTS) begin
      n_eff = 4'(MAX_POINTS);
    end else begin
      n_eff = npts_q;
    end
    if (32'(ndims_q) > MAX_DIMS) begin
      p_eff = 4'(MAX_DIMS);
    end else begin
      p_eff = 4'(ndims_q);
    end
  end

  assign wr_pt  = 32'(in_data_i.point_index);
  assign wr_dm  = 32'(in_data_i.dim_index);
  assign i_wide = 32'(i_q);
  assign j_wide = 32'(j_q);
  assign n_wide = 32'(n_eff);
  assign p_wide = 32'(p_eff);

  assign diff   = {a_q[ped_pkg::COORD_W-1], a_q}
                - {ram_rdata[ped_pkg::COORD_W-1], ram_rdata};
  assign sum_nx = sum_q + ped_pkg::SUM_W'(prod_q);

  // one restoring square-root step: bring down two radicand bits
  assign rem_sh   = {rem_q[ped_pkg::REM_W-3:0], rad_q[ped_pkg::SUM_W-1 -: 2]};
  assign trial    = ped_pkg::REM_W'({root_q, 2'b01});
  assign root_bit = (rem_sh >= trial);
  assign root_nx  = {root_q[ped_pkg::DIST_W-2:0], root_bit};

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    s_d       = s_q;
    step_d    = step_q;
    a_d       = a_q;
    mag_d     = mag_q;
    prod_d    = prod_q;
    sum_d     = sum_q;
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_addr  = {i_q, s_q[DimW-1:0]};
    ram_wdata = in_data_i.coord_value;
    pair_go   = 1'b0;
    root_go   = 1'b0;
    root_rad  = sum_nx;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind == ped_pkg::KIND_WRITE) begin
            ram_addr = {wr_pt[PtW-1:0], wr_dm[DimW-1:0]};
            ram_we   = (wr_pt < MAX_POINTS) && (wr_dm < MAX_DIMS);
          end else if (n_wide >= 32'd2) begin
            i_d     = PtW'(1);
            j_d     = '0;
            pair_go = 1'b1;
          end
        end
      end
      S_RDA: begin
        state_d = S_RDB;
      end
      S_RDB: begin
        ram_addr = {j_q, s_q[DimW-1:0]};
        a_d      = ram_rdata;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        mag_d   = diff[ped_pkg::MAG_W-1] ? ped_pkg::MAG_W'(-diff)
                                         : ped_pkg::MAG_W'(diff);
        state_d = S_SQR;
      end
      S_SQR: begin
        prod_d  = mag_q * mag_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d = sum_nx;
        if (32'(s_q) + 32'd1 < p_wide) begin
          s_d     = s_q + DcntW'(1);
          state_d = S_RDA;
        end else begin
          root_go = 1'b1;
        end
      end
      S_ROOT: begin
        rad_d  = {rad_q[ped_pkg::SUM_W-3:0], 2'b00};
        rem_d  = root_bit ? (rem_sh - trial) : rem_sh;
        root_d = root_nx;
        step_d = step_q + ped_pkg::STEP_W'(1);
        if (32'(step_q) == ped_pkg::DIST_W - 1) begin
          out_d.row_point = i_wide[2:0];
          out_d.col_point = j_wide[2:0];
          out_d.distance  = root_nx;
          out_d.last      = (i_wide + 32'd1 == n_wide) && (j_wide + 32'd2 == n_wide);
          state_d         = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (i_wide + 32'd1 < n_wide) begin
            i_d     = i_q + PtW'(1);
            pair_go = 1'b1;
          end else if (j_wide + 32'd2 < n_wide) begin
            j_d     = j_q + PtW'(1);
            i_d     = j_q + PtW'(2);
            pair_go = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // open a new pair: clear the sum, skip straight to the root with no dims
    if (pair_go) begin
      s_d   = '0;
      sum_d = '0;
      if (p_eff == 4'd0) begin
        root_go  = 1'b1;
        root_rad = '0;
      end else begin
        state_d = S_RDA;
      end
    end

    if (root_go) begin
      rad_d   = root_rad;
      rem_d   = '0;
      root_d  = '0;
      step_d  = '0;
      state_d = S_ROOT;
    end
  end

  ped_ram #(
    .WIDTH (ped_pkg::COORD_W),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      npts_q  <= ped_pkg::NPTS_RESET;
      ndims_q <= ped_pkg::NDIMS_RESET;
      i_q     <= '0;
      j_q     <= '0;
      s_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      s_q     <= s_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ped_pkg::CFG_POINTS: npts_q  <= cfg_data_i;
          ped_pkg::CFG_DIMS:   ndims_q <= cfg_data_i[ped_pkg::NDIMS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

endmodule

/* rtl/ped_checker.sv */
// Port-level checks for the pairwise Euclidean distance block.
// Depends on ped_pkg; bound to the top level at the end of this file.
module ped_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input ped_pkg::out_item_t out_data_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  // no result is offered while new input is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_i |-> !out_valid_i)
    else $error("result offered while idle");

  // the final pair ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && out_data_i.last |=> !out_valid_i && !in_stall_i)
    else $error("run did not end after last transfer");

  // more pairs follow a result that is not the last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !out_data_i.last |=> in_stall_i)
    else $error("run ended before last pair");

endmodule

bind pairwise_euclidean_distance ped_port_checker u_ped_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

/* tb/sv/ped_checker.sv */
`timescale 1ns / 100ps
// Result checker for pairwise_euclidean_distance: mirrors the coordinate store and the
// two registers from observed transfers, predicts every pair distance and compares.
// Depends on ped_pkg for the item types, register indexes and reset values.
module ped_checker
  import ped_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  localparam int unsigned NUM_PTS  = 8;
  localparam int unsigned NUM_DIMS = 4;

  logic signed [COORD_W-1:0] coord_mirror [NUM_PTS][NUM_DIMS];
  logic [NPTS_W-1:0]         npts_q;
  logic [NDIMS_W-1:0]        ndims_q;
  out_item_t                 pair_q [$];
  out_item_t                 want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // bit-by-bit floor root; 18 result bits cover every reachable sum
  function automatic logic [DIST_W-1:0] floor_root(input longint unsigned sq);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] trial;
    longint unsigned   tsq;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (DIST_W'(1) << b);
      tsq   = longint'(trial);
      tsq   = tsq * tsq;
      if (tsq <= sq) root = trial;
    end
    return root;
  endfunction

  function automatic void predict_pairs();
    int unsigned     n;
    int unsigned     p;
    int unsigned     total;
    int unsigned     idx;
    longint unsigned acc;
    longint          diff;
    out_item_t       r;
    n = (npts_q > NUM_PTS) ? NUM_PTS : npts_q;
    p = (ndims_q > NUM_DIMS) ? NUM_DIMS : ndims_q;
    if (n < 2) return;
    total = n * (n - 1) / 2;
    idx   = 0;
    for (int unsigned j = 0; j + 1 < n; j++) begin
      for (int unsigned i = j + 1; i < n; i++) begin
        acc = 0;
        for (int unsigned s = 0; s < p; s++) begin
          diff = longint'(coord_mirror[i][s]) - longint'(coord_mirror[j][s]);
          acc  = acc + longint'(diff * diff);
        end
        r.row_point = 3'(i);
        r.col_point = 3'(j);
        r.distance  = floor_root(acc);
        r.last      = (idx + 1 == total);
        pair_q.push_back(r);
        idx++;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      npts_q  = NPTS_RESET;
      ndims_q = NDIMS_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POINTS) npts_q = cfg_data_i;
        else ndims_q = cfg_data_i[NDIMS_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (pair_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected pair i=%0d j=%0d d=%0d last=%0b", $time,
                   out_data_i.row_point, out_data_i.col_point, out_data_i.distance,
                   out_data_i.last);
        end else begin
          want = pair_q.pop_front();
          checked_o++;
          if (out_data_i.row_point !== want.row_point || out_data_i.col_point !== want.col_point
              || out_data_i.distance !== want.distance || out_data_i.last !== want.last) begin
            fail_count_o++;
            $display("%0t: mismatch exp i=%0d j=%0d d=%0d last=%0b got i=%0d j=%0d d=%0d last=%0b",
                     $time, want.row_point, want.col_point, want.distance, want.last,
                     out_data_i.row_point, out_data_i.col_point, out_data_i.distance,
                     out_data_i.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.kind == KIND_WRITE) begin
          coord_mirror[in_data_i.point_index][in_data_i.dim_index] = in_data_i.coord_value;
        end else begin
          predict_pairs();
        end
      end
    end
    pending_o = pair_q.size();
  end

endmodule

/* tb/sv/tb_pairwise_euclidean_distance.sv */
`timescale 1ns / 100ps
// Testbench top for pairwise_euclidean_distance: clock, reset, coordinate and request
// stimulus, output stall pattern, watchdog and verdict. Depends on ped_pkg and ped_checker.
module tb_pairwise_euclidean_distance;
  import ped_pkg::*;

  localparam int unsigned PAIR_LAT      = 5 * 4 + 19;
  localparam int unsigned SETTLE_CYCLES = 2 * PAIR_LAT;
  localparam int unsigned HOLD_CYCLES   = 2000;
  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS   = 25;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = CFG_POINTS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // stimulus bookkeeping
  bit               written [8][4];
  logic [NPTS_W-1:0]  cur_pts = NPTS_RESET;
  logic [NDIMS_W-1:0] cur_dims = NDIMS_RESET;
  int unsigned      burst_left = 0;
  int unsigned      items_sent = 0;
  int unsigned      writes_sent = 0;
  int unsigned      requests_sent = 0;
  int unsigned      reg_writes = 0;
  bit               hold_req = 1'b0;

  // receiver pattern state
  bit               hold_done = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      mode = 0;
  int unsigned      mode_left = 0;
  logic [1:0]       stall_ph = '0;
  int unsigned      idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pairwise_euclidean_distance u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  ped_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // receiver: one long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    stall_ph <= stall_ph + 2'd1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode      <= $urandom_range(0, 3);
        mode_left <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (stall_ph != 2'd0);
      endcase
    end
  end

  // watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("** pairwise_euclidean_distance: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one item in bursts; hold it until the transfer happens
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  task automatic store_coord(input int unsigned pt, input int unsigned dm,
                             input logic signed [15:0] val);
    in_item_t item;
    item.kind        = KIND_WRITE;
    item.point_index = 3'(pt);
    item.dim_index   = 2'(dm);
    item.coord_value = val;
    written[pt][dm]  = 1'b1;
    send_item(item);
    writes_sent++;
  endtask

  // fill any coordinate the request will read, then issue it
  task automatic request_pairs();
    in_item_t    item;
    int unsigned n;
    int unsigned p;
    n = (cur_pts > 8) ? 8 : cur_pts;
    p = (cur_dims > 4) ? 4 : cur_dims;
    for (int unsigned pt = 0; pt < n; pt++) begin
      for (int unsigned dm = 0; dm < p; dm++) begin
        if (!written[pt][dm]) store_coord(pt, dm, pick_coord());
      end
    end
    item.kind        = KIND_COMPUTE;
    item.point_index = 3'($urandom_range(0, 7));
    item.dim_index   = 2'($urandom_range(0, 3));
    item.coord_value = 16'($urandom);
    send_item(item);
    requests_sent++;
  endtask

  // drop valid, drain expected pairs and let a request with no pairs finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (in_stall) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POINTS) cur_pts = val;
    else cur_dims = val[NDIMS_W-1:0];
    reg_writes++;
  endtask

  initial begin
    logic [CFG_W-1:0] pts_val;
    logic [CFG_W-1:0] dims_val;
    int unsigned      phase_end;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // two points, one dimension: widest difference, then equal points
    set_reg(CFG_POINTS, 4'd2);
    set_reg(CFG_DIMS, 4'd1);
    store_coord(0, 0, 16'sh8000);
    store_coord(1, 0, 16'sh7FFF);
    request_pairs();
    store_coord(1, 0, 16'sh8000);
    request_pairs();
    // no dimensions, then too few points
    settle();
    set_reg(CFG_DIMS, 4'd0);
    request_pairs();
    settle();
    set_reg(CFG_POINTS, 4'd1);
    request_pairs();
    settle();
    set_reg(CFG_POINTS, 4'd0);
    request_pairs();
    // largest distance over all four dimensions
    settle();
    set_reg(CFG_POINTS, 4'd2);
    set_reg(CFG_DIMS, 4'd4);
    store_coord(1, 0, 16'sh7FFF);
    for (int unsigned dm = 1; dm < 4; dm++) begin
      store_coord(0, dm, 16'sh8000);
      store_coord(1, dm, 16'sh7FFF);
    end
    request_pairs();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        // above the store size on both registers
        pts_val  = 4'd15;
        dims_val = 4'd15;
      end else if (ph == 1) begin
        pts_val  = 4'($urandom_range(8, 15));
        dims_val = 4'($urandom_range(0, 15));
      end else if (ph == NUM_PHASES - 1) begin
        pts_val  = 4'd8;
        dims_val = 4'd4;
      end else begin
        pts_val  = 4'($urandom_range(0, 15));
        dims_val = 4'($urandom_range(0, 15));
      end
      set_reg(CFG_POINTS, pts_val);
      set_reg(CFG_DIMS, dims_val);
      if (ph == 1) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) request_pairs();
        else store_coord($urandom_range(0, 7), $urandom_range(0, 3), pick_coord());
      end
      request_pairs();
    end

    settle();
    $display("Run covered %0d items (%0d coordinate writes, %0d pair requests), %0d register writes;",
             items_sent, writes_sent, requests_sent, reg_writes);
    $display("%0d pair distances checked, %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** pairwise_euclidean_distance: PASSED **");
    end else begin
      $display("** pairwise_euclidean_distance: FAILED **");
    end
    $finish;
  end

endmodule
